// File: rtl/fpmm_pkg.sv
`timescale 1ns / 1ps
// fpmm_pkg: types and constants of the single-precision matrix multiply-accumulate core.
// Used by fpmm_fpu and fp32_matrix_multiply_accumulate_core. No dependencies.
package fpmm_pkg;

  localparam int DIM_W = 5;

  localparam logic [2:0] ACT_LOAD_A  = 3'd0;
  localparam logic [2:0] ACT_LOAD_B  = 3'd1;
  localparam logic [2:0] ACT_LOAD_C  = 3'd2;
  localparam logic [2:0] ACT_COMPUTE = 3'd3;
  localparam logic [2:0] ACT_READ_C  = 3'd4;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic FPU_MUL = 1'b0;
  localparam logic FPU_ADD = 1'b1;

  localparam logic [1:0] REG_M_ROWS      = 2'd0;
  localparam logic [1:0] REG_N_COLS      = 2'd1;
  localparam logic [1:0] REG_K_DEPTH     = 2'd2;
  localparam logic [1:0] REG_CLEAR_FIRST = 2'd3;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [31:0] elem_value;
  } cmd_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] result_value;
  } rsp_t;

endpackage

// File: rtl/fpmm_fpu.sv
`timescale 1ns / 1ps
// fpmm_fpu: shared single-precision multiply / add unit, round to nearest even.
// Each operation is prepared (product or aligned sum) into a register, then normalized and rounded.
module fpmm_fpu
  import fpmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        op,
  input  logic [31:0] opa,
  input  logic [31:0] opb,
  output logic        busy,
  output logic        done,
  output logic [31:0] result
);

  logic               s1_valid;
  logic               s1_sign;
  logic [47:0]        s1_sig;
  logic signed [11:0] s1_exp;
  logic               s1_special;
  logic [31:0]        s1_special_val;

  logic               p_sign;
  logic [47:0]        p_sig;
  logic signed [11:0] p_exp;
  logic               p_special;
  logic [31:0]        p_special_val;

  logic [7:0]  ea, eb, ea_eff, eb_eff;
  logic [22:0] fa, fb;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        a_big;
  logic [7:0]  e_big, e_sml, d;
  logic [4:0]  dc;
  logic [23:0] m_big, m_sml;
  logic [53:0] al_wide;
  logic [26:0] al;
  logic [27:0] sum;
  logic        s_big, s_sml;

  // prepare
  always_comb begin
    ea = opa[30:23];
    eb = opb[30:23];
    fa = opa[22:0];
    fb = opb[22:0];
    ea_eff = (ea == 8'd0) ? 8'd1 : ea;
    eb_eff = (eb == 8'd0) ? 8'd1 : eb;
    ma = {ea != 8'd0, fa};
    mb = {eb != 8'd0, fb};
    a_nan  = (ea == 8'hFF) && (fa != 23'd0);
    b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    a_inf  = (ea == 8'hFF) && (fa == 23'd0);
    b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    a_zero = (ea == 8'd0) && (fa == 23'd0);
    b_zero = (eb == 8'd0) && (fb == 23'd0);
    a_big  = opa[30:0] >= opb[30:0];
    e_big  = a_big ? ea_eff : eb_eff;
    e_sml  = a_big ? eb_eff : ea_eff;
    m_big  = a_big ? ma : mb;
    m_sml  = a_big ? mb : ma;
    s_big  = a_big ? opa[31] : opb[31];
    s_sml  = a_big ? opb[31] : opa[31];
    d      = e_big - e_sml;
    dc     = (d > 8'd27) ? 5'd27 : d[4:0];
    al_wide = {m_sml, 3'b000, 27'd0} >> dc;
    al     = al_wide[53:27] | {26'd0, |al_wide[26:0]};
    sum    = (s_big == s_sml) ? ({1'b0, m_big, 3'b000} + {1'b0, al})
                              : ({1'b0, m_big, 3'b000} - {1'b0, al});
    p_special     = 1'b0;
    p_special_val = CANON_NAN;
    if (op == FPU_MUL) begin
      p_sign = opa[31] ^ opb[31];
      p_sig  = ma * mb;
      p_exp  = 12'(ea_eff) + 12'(eb_eff) - 12'sd300;
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
        p_special = 1'b1;
      end else if (a_inf || b_inf) begin
        p_special     = 1'b1;
        p_special_val = {p_sign, 8'hFF, 23'd0};
      end
    end else begin
      // drop to +0 on exact cancellation
      p_sign = (s_big != s_sml && sum == 28'd0) ? 1'b0 : s_big;
      p_sig  = {20'd0, sum};
      p_exp  = 12'(e_big) - 12'sd153;
      if (a_nan || b_nan || (a_inf && b_inf && opa[31] != opb[31])) begin
        p_special = 1'b1;
      end else if (a_inf) begin
        p_special     = 1'b1;
        p_special_val = opa;
      end else if (b_inf) begin
        p_special     = 1'b1;
        p_special_val = opb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    if (start) begin
      s1_sign        <= p_sign;
      s1_sig         <= p_sig;
      s1_exp         <= p_exp;
      s1_special     <= p_special;
      s1_special_val <= p_special_val;
    end
  end

  // normalize and round
  logic [5:0]         msb;
  logic signed [11:0] sh, sh_norm, sh_sub, be;
  logic [4:0]         nsh;
  logic [5:0]         shc;
  logic [95:0]        wide;
  logic [23:0]        m;
  logic               g, st, up;
  logic [24:0]        mr;
  logic [22:0]        frac;
  logic [31:0]        r_val;

  always_comb begin
    msb = 6'd0;
    for (int b = 0; b < 48; b++) begin
      if (s1_sig[b]) msb = 6'(b);
    end
    sh_norm = 12'(msb) - 12'sd23;
    sh_sub  = -12'sd149 - s1_exp;
    sh      = (sh_norm > sh_sub) ? sh_norm : sh_sub;
    nsh     = 5'(-sh);
    shc     = (sh > 12'sd60) ? 6'd60 : 6'(sh);
    wide    = {s1_sig, 48'd0} >> shc;
    if (sh <= 12'sd0) begin
      m  = 24'(s1_sig << nsh);
      g  = 1'b0;
      st = 1'b0;
    end else begin
      m  = wide[71:48];
      g  = wide[47];
      st = |wide[46:0];
    end
    up = g & (st | m[0]);
    mr = {1'b0, m} + {24'd0, up};
    be = sh + s1_exp + 12'sd150;
    frac = mr[22:0];
    if (mr[24]) begin
      be   = be + 12'sd1;
      frac = mr[23:1];
    end else if (!mr[23]) begin
      be = 12'sd0;
    end
    if (s1_special) begin
      r_val = s1_special_val;
    end else if (s1_sig == 48'd0) begin
      r_val = {s1_sign, 31'd0};
    end else if (be >= 12'sd255) begin
      r_val = {s1_sign, 8'hFF, 23'd0};
    end else begin
      r_val = {s1_sign, be[7:0], frac};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    if (s1_valid) begin
      result <= r_val;
    end
  end

  assign busy = s1_valid;

endmodule

// File: rtl/fp32_matrix_multiply_accumulate_core.sv
`timescale 1ns / 1ps
// Top level: single-precision matrix multiply-accumulate with A, B, C stores.
// Depends on fpmm_pkg and fpmm_fpu.
//
//  channel | signals                         | direction | beat
//  --------+---------------------------------+-----------+---------------------------
//  cmd     | cmd_valid, cmd_ready, cmd       | in        | load A/B/C, compute, read C
//  rsp     | rsp_valid, rsp_ready, rsp       | out       | C element or compute done
//  apb     | psel, penable, pwrite, paddr... | in/out    | dimension and clear registers
//
// A compute passes every product and every sum, one after another, through the shared
// multiply/add unit; with K of 0 it uses no arithmetic.
// cmd_ready is low while a command runs and while a response beat waits.
// Reset is synchronous; the stores are not cleared and hold garbage until loaded.
module fp32_matrix_multiply_accumulate_core
  import fpmm_pkg::*;
#(
  parameter int MAX_M = 16,
  parameter int MAX_N = 16,
  parameter int MAX_K = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp
);

  localparam int DA = MAX_M * MAX_K;
  localparam int DB = MAX_K * MAX_N;
  localparam int DC = MAX_M * MAX_N;
  localparam int AW_A = (DA > 1) ? $clog2(DA) : 1;
  localparam int AW_B = (DB > 1) ? $clog2(DB) : 1;
  localparam int AW_C = (DC > 1) ? $clog2(DC) : 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD_WAIT  = 3'd1;
  localparam logic [2:0] S_EL_START = 3'd2;
  localparam logic [2:0] S_EL_ACC   = 3'd3;
  localparam logic [2:0] S_MUL_WAIT = 3'd4;
  localparam logic [2:0] S_ADD_WAIT = 3'd5;
  localparam logic [2:0] S_WRITE    = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  // configuration registers
  logic [DIM_W-1:0] m_rows, n_cols, k_depth;
  logic             clear_first;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_rows      <= DIM_W'(16);
      n_cols      <= DIM_W'(16);
      k_depth     <= DIM_W'(16);
      clear_first <= 1'b1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_M_ROWS:      m_rows      <= pwdata[DIM_W-1:0];
        REG_N_COLS:      n_cols      <= pwdata[DIM_W-1:0];
        REG_K_DEPTH:     k_depth     <= pwdata[DIM_W-1:0];
        REG_CLEAR_FIRST: clear_first <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_M_ROWS:      prdata = 32'(m_rows);
      REG_N_COLS:      prdata = 32'(n_cols);
      REG_K_DEPTH:     prdata = 32'(k_depth);
      REG_CLEAR_FIRST: prdata = 32'(clear_first);
      default:         prdata = 32'd0;
    endcase
  end

  logic [DIM_W-1:0] m_eff, n_eff, k_eff;
  assign m_eff = (32'(m_rows) > MAX_M) ? DIM_W'(MAX_M) : m_rows;
  assign n_eff = (32'(n_cols) > MAX_N) ? DIM_W'(MAX_N) : n_cols;
  assign k_eff = (32'(k_depth) > MAX_K) ? DIM_W'(MAX_K) : k_depth;

  // sequencer state
  logic [2:0]       state;
  logic [DIM_W-1:0] i, j, k;
  logic             last;
  logic [31:0]      acc;
  logic             accept;

  assign cmd_ready = (state == S_IDLE) && !rsp_valid;
  assign accept    = cmd_valid && cmd_ready;

  logic in_a, in_b, in_c;
  assign in_a = (32'(cmd.row_index) < MAX_M) && (32'(cmd.col_index) < MAX_K);
  assign in_b = (32'(cmd.row_index) < MAX_K) && (32'(cmd.col_index) < MAX_N);
  assign in_c = (32'(cmd.row_index) < MAX_M) && (32'(cmd.col_index) < MAX_N);

  // stores
  logic [31:0] store_a [DA];
  logic [31:0] store_b [DB];
  logic [31:0] store_c [DC];
  logic [31:0] a_q, b_q, c_q;
  logic [AW_A-1:0] a_waddr, a_raddr;
  logic [AW_B-1:0] b_waddr, b_raddr;
  logic [AW_C-1:0] c_waddr, c_raddr, c_cmd_addr, c_el_addr;
  logic            a_we, b_we, c_we;
  logic [31:0]     c_wdata, acc_out;

  assign a_waddr    = AW_A'(32'(cmd.row_index) * MAX_K + 32'(cmd.col_index));
  assign b_waddr    = AW_B'(32'(cmd.row_index) * MAX_N + 32'(cmd.col_index));
  assign c_cmd_addr = AW_C'(32'(cmd.row_index) * MAX_N + 32'(cmd.col_index));
  assign c_el_addr  = AW_C'(32'(i) * MAX_N + 32'(j));
  assign a_raddr    = AW_A'(32'(i) * MAX_K + 32'(k));
  assign b_raddr    = AW_B'(32'(k) * MAX_N + 32'(j));
  assign c_raddr    = (state == S_IDLE) ? c_cmd_addr : c_el_addr;

  assign a_we = accept && (cmd.action == ACT_LOAD_A) && in_a;
  assign b_we = accept && (cmd.action == ACT_LOAD_B) && in_b;

  // any NaN sum goes out as the canonical quiet NaN
  assign acc_out = ((acc[30:23] == 8'hFF) && (acc[22:0] != 23'd0)) ? CANON_NAN : acc;

  always_comb begin
    c_we    = 1'b0;
    c_waddr = c_el_addr;
    c_wdata = acc_out;
    if (accept && (cmd.action == ACT_LOAD_C) && in_c) begin
      c_we    = 1'b1;
      c_waddr = c_cmd_addr;
      c_wdata = cmd.elem_value;
    end else if (state == S_EL_START && k_eff == '0 && clear_first) begin
      c_we    = 1'b1;
      c_wdata = 32'd0;
    end else if (state == S_WRITE) begin
      c_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) store_a[a_waddr] <= cmd.elem_value;
    a_q <= store_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) store_b[b_waddr] <= cmd.elem_value;
    b_q <= store_b[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) store_c[c_waddr] <= c_wdata;
    c_q <= store_c[c_raddr];
  end

  // shared arithmetic unit
  logic        fpu_start, fpu_op, fpu_busy, fpu_done;
  logic [31:0] fpu_a, fpu_b, fpu_res;

  always_comb begin
    fpu_start = 1'b0;
    fpu_op    = FPU_MUL;
    fpu_a     = a_q;
    fpu_b     = b_q;
    case (state)
      S_EL_ACC: fpu_start = 1'b1;
      S_MUL_WAIT: begin
        fpu_start = fpu_done;
        fpu_op    = FPU_ADD;
        fpu_a     = acc;
        fpu_b     = fpu_res;
      end
      S_ADD_WAIT: fpu_start = fpu_done && !last;
      default: ;
    endcase
  end

  fpmm_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (fpu_start),
    .op     (fpu_op),
    .opa    (fpu_a),
    .opb    (fpu_b),
    .busy   (fpu_busy),
    .done   (fpu_done),
    .result (fpu_res)
  );

  logic el_last_j, el_last_i;
  assign el_last_j = (j + 1'b1) == n_eff;
  assign el_last_i = (i + 1'b1) == m_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      last      <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      // advance k whenever a product is launched; its operands are already captured
      if (fpu_start && fpu_op == FPU_MUL) begin
        k    <= k + 1'b1;
        last <= (k + 1'b1) == k_eff;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.action)
              ACT_COMPUTE: begin
                i <= '0;
                j <= '0;
                k <= '0;
                state <= (m_eff == '0 || n_eff == '0) ? S_DONE : S_EL_START;
              end
              ACT_READ_C: begin
                if (in_c) begin
                  state <= S_RD_WAIT;
                end else begin
                  rsp_valid <= 1'b1;
                  rsp       <= '{result_kind: KIND_READ, result_value: 32'd0};
                end
              end
              default: ;
            endcase
          end
        end
        S_RD_WAIT: begin
          rsp_valid <= 1'b1;
          rsp       <= '{result_kind: KIND_READ, result_value: c_q};
          state     <= S_IDLE;
        end
        S_EL_START: begin
          if (k_eff == '0) begin
            k <= '0;
            if (el_last_j) begin
              j <= '0;
              i <= i + 1'b1;
              state <= el_last_i ? S_DONE : S_EL_START;
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            state <= S_EL_ACC;
          end
        end
        S_EL_ACC: begin
          acc   <= clear_first ? 32'd0 : c_q;
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (fpu_done) state <= S_ADD_WAIT;
        end
        S_ADD_WAIT: begin
          if (fpu_done) begin
            acc   <= fpu_res;
            state <= last ? S_WRITE : S_MUL_WAIT;
          end
        end
        S_WRITE: begin
          k <= '0;
          if (el_last_j) begin
            j <= '0;
            i <= i + 1'b1;
            state <= el_last_i ? S_DONE : S_EL_START;
          end else begin
            j <= j + 1'b1;
            state <= S_EL_START;
          end
        end
        S_DONE: begin
          rsp_valid <= 1'b1;
          rsp       <= '{result_kind: KIND_DONE, result_value: 32'd0};
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fpu_free: assert property (@(posedge clk) disable iff (rst)
    fpu_start |-> !fpu_busy) else $error("fpu started while busy");

  a_k_fresh: assert property (@(posedge clk) disable iff (rst)
    state == S_EL_ACC |-> k == '0) else $error("element started with nonzero k");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    fpu_done |-> (state == S_MUL_WAIT || state == S_ADD_WAIT))
    else $error("fpu result with no consumer");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> !fpu_busy && !fpu_done) else $error("ready while arithmetic runs");

  a_write_next: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |=> (state == S_EL_START || state == S_DONE))
    else $error("bad step after element write");

endmodule

// File: bench/fp32_matrix_multiply_accumulate_core_tb.sv
`timescale 1ns / 1ps
// Testbench for fp32_matrix_multiply_accumulate_core: directed and random loads, computes and reads,
// checked against an in-bench single-precision predictor. Depends on fpmm_pkg and the RTL.
module fp32_matrix_multiply_accumulate_core_tb;
  import fpmm_pkg::*;

  localparam int DIM = 16;
  localparam longint CYCLE_LIMIT = 4000000;

  class matmul_tracker;
    logic [31:0] mat_a [DIM*DIM];
    logic [31:0] mat_b [DIM*DIM];
    logic [31:0] mat_c [DIM*DIM];
    int unsigned m_rows = 16, n_cols = 16, k_depth = 16;
    bit clear_first = 1;
    rsp_t pending[$];
    int errors = 0;

    static function real bits_to_real(logic [31:0] b);
      if (b[30:23] == 8'hFF) begin
        if (b[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
        return $bitstoreal({b[31], 11'h7FF, 52'h0});
      end
      if (b[30:23] == 8'h00) begin
        if (b[22:0] == 0) return $bitstoreal({b[31], 63'h0});
        return b[31] ? -(real'(b[22:0]) * 2.0**(-149)) : real'(b[22:0]) * 2.0**(-149);
      end
      return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'h0});
    endfunction

    // round a double to single, nearest even; inputs are sums or products of singles (products are exact)
    static function logic [31:0] real_to_bits(real r);
      logic [63:0] d;
      longint unsigned mant, q, rem, half, mag;
      int ue, sh, base;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {d[63], 31'h7F80_0000};
      if (d[62:52] == 11'h000) return {d[63], 31'h0};
      ue = int'(d[62:52]) - 1023;
      if (ue > 127) return {d[63], 31'h7F80_0000};
      mant = {12'h001, d[51:0]};
      if (ue >= -126) begin
        sh = 29;
        base = ue + 126;
      end else begin
        sh = 29 + (-126 - ue);
        base = 0;
      end
      if (sh > 60) return {d[63], 31'h0};
      q = mant >> sh;
      rem = mant & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      mag = (longint'(base) << 23) + q;
      if (mag >= 64'h7F80_0000) return {d[63], 31'h7F80_0000};
      return {d[63], mag[30:0]};
    endfunction

    function void run_product();
      int unsigned m, n, kd;
      logic [31:0] acc, prod;
      m = (m_rows > DIM) ? DIM : m_rows;
      n = (n_cols > DIM) ? DIM : n_cols;
      kd = (k_depth > DIM) ? DIM : k_depth;
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < n; j++) begin
          if (clear_first) mat_c[i*DIM+j] = 32'h0;
          if (kd == 0) continue;
          acc = mat_c[i*DIM+j];
          for (int k = 0; k < kd; k++) begin
            prod = real_to_bits(bits_to_real(mat_a[i*DIM+k]) * bits_to_real(mat_b[k*DIM+j]));
            acc = real_to_bits(bits_to_real(acc) + bits_to_real(prod));
          end
          if (acc[30:23] == 8'hFF && acc[22:0] != 0) acc = CANON_NAN;
          mat_c[i*DIM+j] = acc;
        end
      end
    endfunction

    function void note_command(cmd_t c);
      rsp_t r;
      case (c.action)
        ACT_LOAD_A: mat_a[c.row_index*DIM + c.col_index] = c.elem_value;
        ACT_LOAD_B: mat_b[c.row_index*DIM + c.col_index] = c.elem_value;
        ACT_LOAD_C: mat_c[c.row_index*DIM + c.col_index] = c.elem_value;
        ACT_COMPUTE: begin
          run_product();
          r.result_kind = KIND_DONE;
          r.result_value = 32'h0;
          pending.push_back(r);
        end
        ACT_READ_C: begin
          r.result_kind = KIND_READ;
          r.result_value = mat_c[c.row_index*DIM + c.col_index];
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat kind=%0d value=%h", got.result_kind, got.result_value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind expected %0d actual %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.result_value !== want.result_value) begin
        $error("result_value expected %h actual %h", want.result_value, got.result_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  matmul_tracker tracker = new();
  longint cycles = 0;
  int stall_left = 0;

  always #4 clk = ~clk;

  fp32_matrix_multiply_accumulate_core i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fp32_matrix_multiply_accumulate_core verification failed");
      $finish;
    end
  end

  // check accepted result beats, then pick the ready for the next cycle
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) tracker.check_result(rsp);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 8) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 3);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_value();
    int sel;
    logic [31:0] specials [8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                  32'h7FC0_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h0080_0000};
    sel = $urandom_range(0, 99);
    if (sel < 4) return specials[$urandom_range(0, 7)];
    if (sel < 12) return $urandom();
    return {1'($urandom()), 8'($urandom_range(118, 136)), 23'($urandom())};
  endfunction

  task automatic send_cmd(logic [2:0] act, logic [3:0] row, logic [3:0] col, logic [31:0] val);
    int gap, sel;
    cmd_t c;
    c.action = act;
    c.row_index = row;
    c.col_index = col;
    c.elem_value = val;
    sel = $urandom_range(0, 99);
    if (sel < 60) gap = 0;
    else if (sel < 90) gap = $urandom_range(1, 3);
    else if (sel < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 50);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    tracker.note_command(c);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    // loads give no beat: let the last one land
    repeat (12) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // hold the bus idle before the next setup
    @(posedge clk);
    case (idx)
      REG_M_ROWS:  tracker.m_rows = data[4:0];
      REG_N_COLS:  tracker.n_cols = data[4:0];
      REG_K_DEPTH: tracker.k_depth = data[4:0];
      default:     tracker.clear_first = data[0];
    endcase
  endtask

  task automatic set_dims(int m, int n, int k, bit clr);
    drain();
    apb_write(REG_M_ROWS, m);
    apb_write(REG_N_COLS, n);
    apb_write(REG_K_DEPTH, k);
    apb_write(REG_CLEAR_FIRST, 32'(clr));
  endtask

  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return 0;
    if (sel < 12) return $urandom_range(16, 31);
    if (sel < 20) return $urandom_range(5, 15);
    return $urandom_range(1, 4);
  endfunction

  initial begin
    int sel, computes, cap;
    logic [2:0] act;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every store so that nothing read is ever undefined
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c < DIM; c++) begin
        send_cmd(ACT_LOAD_A, 4'(r), 4'(c), pick_value());
        send_cmd(ACT_LOAD_B, 4'(r), 4'(c), pick_value());
        send_cmd(ACT_LOAD_C, 4'(r), 4'(c), pick_value());
      end

    // directed: field extremes, specials, unknown actions, empty inner dimension, zero and oversize sizes
    set_dims(2, 2, 2, 1'b0);
    send_cmd(ACT_LOAD_A, 0, 0, 32'h7F80_0000);
    send_cmd(ACT_LOAD_A, 0, 1, 32'hFFFF_FFFF);
    send_cmd(ACT_LOAD_B, 0, 0, 32'h0);
    send_cmd(ACT_LOAD_B, 1, 1, 32'h7F7F_FFFF);
    send_cmd(ACT_LOAD_A, 1, 0, 32'h0000_0001);
    send_cmd(ACT_LOAD_B, 0, 1, 32'h8000_0000);
    send_cmd(ACT_LOAD_C, 1, 1, 32'h7F7F_FFFF);
    send_cmd(3'd5, 15, 15, 32'hFFFF_FFFF);
    send_cmd(3'd6, 0, 0, 32'h0);
    send_cmd(3'd7, 7, 9, 32'h1234_5678);
    send_cmd(ACT_COMPUTE, 15, 15, 32'hFFFF_FFFF);
    send_cmd(ACT_READ_C, 0, 0, 32'h0);
    send_cmd(ACT_READ_C, 0, 1, 32'h0);
    send_cmd(ACT_READ_C, 1, 1, 32'h0);
    send_cmd(ACT_READ_C, 15, 15, 32'h0);
    set_dims(3, 4, 0, 1'b1);
    send_cmd(ACT_COMPUTE, 0, 0, 32'h0);
    send_cmd(ACT_READ_C, 2, 3, 32'h0);
    set_dims(31, 31, 31, 1'b0);
    send_cmd(ACT_COMPUTE, 0, 0, 32'h0);
    send_cmd(ACT_READ_C, 15, 0, 32'h0);
    set_dims(0, 0, 16, 1'b1);
    send_cmd(ACT_COMPUTE, 0, 0, 32'h0);
    send_cmd(ACT_READ_C, 3, 3, 32'h0);

    for (int phase = 0; phase < 12; phase++) begin
      set_dims(pick_dim(), pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
      cap = (tracker.m_rows * tracker.n_cols * tracker.k_depth > 300) ? 1 : 6;
      computes = 0;
      for (int it = 0; it < 60; it++) begin
        sel = $urandom_range(0, 99);
        if (sel < 20) act = ACT_LOAD_A;
        else if (sel < 40) act = ACT_LOAD_B;
        else if (sel < 60) act = ACT_LOAD_C;
        else if (sel < 95) act = ACT_READ_C;
        else if (sel < 98) act = 3'($urandom_range(5, 7));
        else act = ACT_COMPUTE;
        if (act == ACT_COMPUTE) begin
          if (computes >= cap) act = ACT_READ_C;
          else computes++;
        end
        // keep loads and reads mostly inside rows and columns 0 to 4
        if ($urandom_range(0, 3) != 0)
          send_cmd(act, 4'($urandom_range(0, 4)), 4'($urandom_range(0, 4)), pick_value());
        else
          send_cmd(act, 4'($urandom()), 4'($urandom()), pick_value());
      end
      if (computes == 0) send_cmd(ACT_COMPUTE, 0, 0, 32'h0);
      for (int r = 0; r < 3; r++) send_cmd(ACT_READ_C, 4'($urandom_range(0, 3)), 4'(r), 32'h0);
    end

    cmd_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0)
      $display("fp32_matrix_multiply_accumulate_core verification clean");
    else
      $display("fp32_matrix_multiply_accumulate_core verification failed");
    $finish;
  end
endmodule

// File: files.f
rtl/fpmm_pkg.sv
rtl/fpmm_fpu.sv
rtl/fp32_matrix_multiply_accumulate_core.sv
bench/fp32_matrix_multiply_accumulate_core_tb.sv
